// ===== design/wad_pkg.sv =====
// Shared types, constants and tables for the weighted arc cosine distance block.
package wad_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int VAL_W       = 16;
    localparam int TOL_W       = 16;
    localparam int ANGLE_W     = 15;
    localparam int CNT_W       = 7;
    localparam int STEP_W      = 7;
    localparam int Z_W         = 24;
    localparam int CX_W        = 34;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd429;

    localparam int PMUL_STEPS   = 4;
    localparam int SQRT_STEPS   = 64;
    localparam int DIV_STEPS    = 30;
    localparam int CORDIC_STEPS = 21;

    localparam logic [22:0] HALF_PI_Q20 = 23'd1647099;
    localparam logic [22:0] PI_Q20      = 23'd3294199;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_TOL = 2'd1,
        ST_SAT = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_MUL1,
        OP_MUL2,
        OP_ACC,
        OP_PMUL,
        OP_SQRT,
        OP_CHK,
        OP_DIV,
        OP_SQ,
        OP_CORD,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [STEP_W-1:0] step;
        t_status           res;
    } t_cmd;

    typedef struct packed {
        logic sat;
        logic last;
        logic tol;
        logic full;
        logic out_free;
    } t_sts;

    function automatic logic signed [Z_W-1:0] atan_q20(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 24'sd823550;
            5'd1:    v = 24'sd486170;
            5'd2:    v = 24'sd256879;
            5'd3:    v = 24'sd130396;
            5'd4:    v = 24'sd65451;
            5'd5:    v = 24'sd32757;
            5'd6:    v = 24'sd16383;
            5'd7:    v = 24'sd8192;
            5'd8:    v = 24'sd4096;
            5'd9:    v = 24'sd2048;
            5'd10:   v = 24'sd1024;
            5'd11:   v = 24'sd512;
            5'd12:   v = 24'sd256;
            5'd13:   v = 24'sd128;
            5'd14:   v = 24'sd64;
            5'd15:   v = 24'sd32;
            5'd16:   v = 24'sd16;
            5'd17:   v = 24'sd8;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            5'd20:   v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/weighted_arccos_distance_top.sv =====
// Weighted arc cosine distance: weights are stored on accept; a pair feature passes two
// multiply states and an accumulate state. The last feature can add 4 partial products,
// two 64-step square roots, a 30-step divide and 21 CORDIC steps on one shared datapath.
// One transaction is in flight at a time; a finished result waits in the output register.
// Synchronous active-low reset clears the pair accumulators and sets the tolerance to 429;
// the weight store is not cleared and every weight must be written before use.
module weighted_arccos_distance_top #(
    parameter int MAX_FEATURES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic [wad_pkg::IDX_W-1:0]           i_weight_index,
    input  logic [wad_pkg::VAL_W-1:0]           i_weight_value,
    input  logic signed [wad_pkg::VAL_W-1:0]    i_a_value,
    input  logic signed [wad_pkg::VAL_W-1:0]    i_b_value,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [wad_pkg::ANGLE_W-1:0]         o_angle,
    output logic [1:0]                          o_status,
    input  logic                                i_cfg_we,
    input  logic [wad_pkg::TOL_W-1:0]           i_cfg_data
);
    import wad_pkg::*;

    t_cmd cmd;
    t_sts sts;

    wad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    wad_dp #(.MAX_FEATURES(MAX_FEATURES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_kind),
        .i_weight_index (i_weight_index),
        .i_weight_value (i_weight_value),
        .i_a_value      (i_a_value),
        .i_b_value      (i_b_value),
        .i_last         (i_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_angle        (o_angle),
        .o_status       (o_status)
    );
endmodule

// ===== design/wad_ram.sv =====
// Generic single-port-write, registered-read RAM.
module wad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/wad_ctrl.sv =====
// Sequencer for accumulation and the final angle computation.
module wad_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_kind,
    input  wad_pkg::t_sts i_sts,
    output wad_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import wad_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MUL1  = 13'b0000000000010,
        S_MUL2  = 13'b0000000000100,
        S_ACC   = 13'b0000000001000,
        S_FIN   = 13'b0000000010000,
        S_PMUL  = 13'b0000000100000,
        S_SQRT  = 13'b0000001000000,
        S_CHK   = 13'b0000010000000,
        S_DIV   = 13'b0000100000000,
        S_SQ    = 13'b0001000000000,
        S_SQRT2 = 13'b0010000000000,
        S_CORD  = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_status           r_res, n_res;
    t_op               op;

    always_comb begin
        n_state = r_state;
        n_step  = r_step + STEP_W'(1);
        n_res   = r_res;
        op      = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op = OP_ACCEPT;
                    if (i_kind) begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                op      = OP_MUL1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                op      = OP_MUL2;
                n_state = S_ACC;
            end
            S_ACC: begin
                op      = OP_ACC;
                n_state = i_sts.last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                n_step = '0;
                if (i_sts.sat) begin
                    n_res   = ST_SAT;
                    n_state = S_OUT;
                end else begin
                    n_state = S_PMUL;
                end
            end
            S_PMUL: begin
                op = OP_PMUL;
                if (r_step == STEP_W'(PMUL_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                op = OP_SQRT;
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                op     = OP_CHK;
                n_step = '0;
                if (i_sts.tol) begin
                    n_res   = ST_TOL;
                    n_state = S_OUT;
                end else begin
                    n_res   = ST_OK;
                    n_state = i_sts.full ? S_OUT : S_DIV;
                end
            end
            S_DIV: begin
                op = OP_DIV;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                op      = OP_SQ;
                n_step  = '0;
                n_state = S_SQRT2;
            end
            S_SQRT2: begin
                op = OP_SQRT;
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_CORD;
                end
            end
            S_CORD: begin
                op = OP_CORD;
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_step = '0;
                if (i_sts.out_free) begin
                    op      = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_res   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_res   <= n_res;
        end
    end

    assign o_cmd.op   = op;
    assign o_cmd.step = r_step;
    assign o_cmd.res  = r_res;
    assign o_in_stall = (r_state != S_IDLE);

    a_out_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_OUT) |-> i_sts.out_free)
        else $error("result written while output slot busy");

    a_accept_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_ACCEPT) |=> (r_state == S_IDLE || r_state == S_MUL1))
        else $error("accept did not lead to idle or multiply");
endmodule

// ===== design/wad_dp.sv =====
// Datapath: weight store, multiply-accumulate, square root, divide and CORDIC.
module wad_dp #(
    parameter int MAX_FEATURES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wad_pkg::t_cmd                i_cmd,
    input  logic                         i_kind,
    input  logic [wad_pkg::IDX_W-1:0]    i_weight_index,
    input  logic [wad_pkg::VAL_W-1:0]    i_weight_value,
    input  logic signed [wad_pkg::VAL_W-1:0] i_a_value,
    input  logic signed [wad_pkg::VAL_W-1:0] i_b_value,
    input  logic                         i_last,
    input  logic                         i_cfg_we,
    input  logic [wad_pkg::TOL_W-1:0]    i_cfg_data,
    input  logic                         i_out_stall,
    output wad_pkg::t_sts                o_sts,
    output logic                         o_out_valid,
    output logic [wad_pkg::ANGLE_W-1:0]  o_angle,
    output logic [1:0]                   o_status
);
    import wad_pkg::*;

    localparam int LIMIT = (MAX_FEATURES < STORE_DEPTH) ? MAX_FEATURES : STORE_DEPTH;

    logic [VAL_W-1:0]        ram_rdata;
    logic                    ram_we;

    logic signed [VAL_W-1:0] r_a, r_b;
    logic                    r_last, r_skip;
    logic [31:0]             r_w2, r_aa, r_bb;
    logic signed [31:0]      r_ab;
    logic [63:0]             r_tdot, r_ta, r_tb;
    logic [CNT_W-1:0]        r_count;
    logic [63:0]             r_dot, r_na, r_nb;
    logic                    r_sat;
    logic [TOL_W-1:0]        r_tol;
    logic [127:0]            r_x;
    logic [63:0]             r_root;
    logic [66:0]             r_rem;
    logic [63:0]             r_den, r_drem;
    logic [29:0]             r_q;
    logic                    r_neg;
    logic signed [CX_W-1:0]  r_cx, r_cy;
    logic signed [Z_W-1:0]   r_z;
    logic                    r_out_valid;
    logic [ANGLE_W-1:0]      r_angle;
    logic [1:0]              r_status;

    logic [31:0]             w2_c;
    logic signed [31:0]      ab_c, aa_c, bb_c;
    logic signed [64:0]      tdot_c;
    logic [63:0]             ta_c, tb_c;
    logic [64:0]             dsum, nasum, nbsum;
    logic                    dovf;
    logic [63:0]             dsat;
    logic [31:0]             pa, pb;
    logic [63:0]             pp;
    logic [6:0]              pshamt;
    logic [127:0]            pshift;
    logic [66:0]             rem_in, remp, trial;
    logic [63:0]             root_in;
    logic                    dneg;
    logic [63:0]             mag, tol64, diff;
    logic                    close;
    logic [64:0]             rem2;
    logic [59:0]             qq;
    logic [60:0]             sqv;
    logic [4:0]              ci;
    logic signed [CX_W-1:0]  cx_in, cy_in, xs, ys;
    logic signed [Z_W-1:0]   z_in, at;
    logic [22:0]             zc, zf, zr;
    logic                    out_free;

    wad_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_weight_index),
        .i_wdata (i_weight_value),
        .i_raddr (r_count[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign ram_we = (i_cmd.op == OP_ACCEPT) && !i_kind;

    always_comb begin
        w2_c   = ram_rdata * ram_rdata;
        ab_c   = r_a * r_b;
        aa_c   = r_a * r_a;
        bb_c   = r_b * r_b;
        tdot_c = $signed({1'b0, r_w2}) * r_ab;
        ta_c   = r_w2 * r_aa;
        tb_c   = r_w2 * r_bb;

        dsum  = {r_dot[63], r_dot} + {r_tdot[63], r_tdot};
        dovf  = dsum[64] ^ dsum[63];
        dsat  = dsum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        nasum = {1'b0, r_na} + {1'b0, r_ta};
        nbsum = {1'b0, r_nb} + {1'b0, r_tb};

        pa     = i_cmd.step[1] ? r_na[63:32] : r_na[31:0];
        pb     = i_cmd.step[0] ? r_nb[63:32] : r_nb[31:0];
        pp     = pa * pb;
        pshamt = {i_cmd.step[1] & i_cmd.step[0], i_cmd.step[1] ^ i_cmd.step[0], 5'd0};
        pshift = {64'd0, pp} << pshamt;

        rem_in  = (i_cmd.step == '0) ? 67'd0 : r_rem;
        root_in = (i_cmd.step == '0) ? 64'd0 : r_root;
        remp    = {rem_in[64:0], r_x[127:126]};
        trial   = {1'b0, root_in, 2'b01};

        dneg  = r_dot[63];
        mag   = dneg ? (64'd0 - r_dot) : r_dot;
        tol64 = {{(64 - TOL_W){1'b0}}, r_tol};
        diff  = (mag >= r_root) ? (mag - r_root) : (r_root - mag);
        if (!dneg) begin
            close = diff < tol64;
        end else begin
            close = (mag < tol64) && (r_root < (tol64 - mag));
        end

        rem2 = {r_drem, 1'b0};
        qq   = r_q * r_q;
        sqv  = {1'b1, 60'd0} - {1'b0, qq};

        ci    = i_cmd.step[4:0];
        cx_in = (i_cmd.step == '0) ? $signed({4'd0, r_q}) : r_cx;
        cy_in = (i_cmd.step == '0) ? $signed({3'd0, r_root[30:0]}) : r_cy;
        z_in  = (i_cmd.step == '0) ? '0 : r_z;
        xs    = cx_in >>> ci;
        ys    = cy_in >>> ci;
        at    = atan_q20(ci);

        if (r_z < 0) begin
            zc = '0;
        end else if (r_z > $signed({1'b0, HALF_PI_Q20})) begin
            zc = HALF_PI_Q20;
        end else begin
            zc = r_z[22:0];
        end
        zf = r_neg ? (PI_Q20 - zc) : zc;
        zr = zf + 23'd64;

        out_free = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dot       <= '0;
            r_na        <= '0;
            r_nb        <= '0;
            r_sat       <= 1'b0;
            r_tol       <= TOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && i_cmd.op != OP_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_ACCEPT: begin
                    r_a    <= i_a_value;
                    r_b    <= i_b_value;
                    r_last <= i_last;
                    r_skip <= (r_count >= CNT_W'(LIMIT));
                end
                OP_MUL1: begin
                    r_w2 <= w2_c;
                    r_ab <= ab_c;
                    r_aa <= $unsigned(aa_c);
                    r_bb <= $unsigned(bb_c);
                end
                OP_MUL2: begin
                    r_tdot <= tdot_c[63:0];
                    r_ta   <= ta_c;
                    r_tb   <= tb_c;
                end
                OP_ACC: begin
                    if (r_skip) begin
                        r_sat <= 1'b1;
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                        r_dot   <= dovf ? dsat : dsum[63:0];
                        r_na    <= nasum[64] ? {64{1'b1}} : nasum[63:0];
                        r_nb    <= nbsum[64] ? {64{1'b1}} : nbsum[63:0];
                        if (dovf || nasum[64] || nbsum[64]) begin
                            r_sat <= 1'b1;
                        end
                    end
                end
                OP_PMUL: begin
                    r_x <= ((i_cmd.step == '0) ? 128'd0 : r_x) + pshift;
                end
                OP_SQRT: begin
                    r_x <= {r_x[125:0], 2'b00};
                    if (remp >= trial) begin
                        r_rem  <= remp - trial;
                        r_root <= {root_in[62:0], 1'b1};
                    end else begin
                        r_rem  <= remp;
                        r_root <= {root_in[62:0], 1'b0};
                    end
                end
                OP_CHK: begin
                    r_den  <= r_root;
                    r_drem <= mag;
                    r_neg  <= dneg;
                    r_q    <= '0;
                    r_z    <= '0;
                end
                OP_DIV: begin
                    if (rem2 >= {1'b0, r_den}) begin
                        r_drem <= 64'(rem2 - {1'b0, r_den});
                        r_q    <= {r_q[28:0], 1'b1};
                    end else begin
                        r_drem <= rem2[63:0];
                        r_q    <= {r_q[28:0], 1'b0};
                    end
                end
                OP_SQ: begin
                    r_x <= {67'd0, sqv};
                end
                OP_CORD: begin
                    if (cy_in > 0) begin
                        r_cx <= cx_in + ys;
                        r_cy <= cy_in - xs;
                        r_z  <= z_in + at;
                    end else begin
                        r_cx <= cx_in - ys;
                        r_cy <= cy_in + xs;
                        r_z  <= z_in - at;
                    end
                end
                OP_OUT: begin
                    r_out_valid <= 1'b1;
                    r_status    <= i_cmd.res;
                    r_angle     <= (i_cmd.res == ST_OK) ? zr[21:7] : '0;
                    r_count     <= '0;
                    r_dot       <= '0;
                    r_na        <= '0;
                    r_nb        <= '0;
                    r_sat       <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.sat      = r_sat;
    assign o_sts.last     = r_last;
    assign o_sts.tol      = close || (r_root == '0);
    assign o_sts.full     = mag >= r_root;
    assign o_sts.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_angle     = r_angle;
    assign o_status    = r_status;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LIMIT))
        else $error("feature count beyond limit");

    a_pair_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_OUT) |=> (r_count == '0 && !r_sat && r_dot == '0))
        else $error("pair state not cleared after result");

    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_angle == '0))
        else $error("shortcut result with nonzero angle");
endmodule
